// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

  localparam int DATA_W           = 32;
  localparam int DEFAULT_CAPACITY = 64;

  // Input item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_LIST   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_ENTRY   = 2'd0;
  localparam logic [1:0] ST_REMOVED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_REM_RD,
    S_REM_EMIT,
    S_SHF_RD,
    S_SHF_WR,
    S_LST_RD,
    S_LST_EMIT,
    S_FULL,
    S_EMPTY
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_PREV,
    RA_NEXT
  } rd_addr_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic       load_val;
    idx_op_t    idx_op;
    logic       rd_en;
    rd_addr_t   rd_addr;
    logic       wr_en;
    logic       wr_from_val;
    cnt_op_t    cnt_op;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_zero;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_last;
    logic full;
    logic empty;
    logic count_one;
    logic gt;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/spq_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the sorted priority queue: entry store, index, count, output register.
// Depends on spq_pkg; driven by spq_controller through cmd_t, reports through sts_t.
module spq_datapath import spq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] value_res,
  output logic                     last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] val;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     idx_dec;
  logic [CW-1:0]     rd_idx;
  logic [DATA_W-1:0] wr_data;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign wr_data = cmd.wr_from_val ? val : rd_data;

  always_comb begin
    case (cmd.rd_addr)
      RA_PREV: rd_idx = idx_dec;
      RA_NEXT: rd_idx = idx_inc;
      default: rd_idx = idx;
    endcase
  end

  // Entry store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_val) begin
      val <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      case (cmd.idx_op)
        IDX_COUNT: idx <= count;
        IDX_ZERO:  idx <= '0;
        IDX_INC:   idx <= idx_inc;
        IDX_DEC:   idx <= idx_dec;
        default:   idx <= idx;
      endcase
      case (cmd.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= cmd.out_status;
      value_res <= cmd.out_zero ? '0 : $signed(rd_data);
      last      <= cmd.out_last;
    end
  end

  assign sts.idx_zero  = (idx == '0);
  assign sts.idx_last  = (idx_inc == count);
  assign sts.full      = (count == CW'(CAPACITY));
  assign sts.empty     = (count == '0);
  assign sts.count_one = (count == CW'(1));
  assign sts.gt        = ($signed(rd_data) > $signed(val));
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ----- rtl/spq_controller.sv -----
`timescale 1ns / 1ps
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg; commands spq_datapath through cmd_t and reads sts_t.
module spq_controller import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   list_after;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      list_after <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        list_after <= (kind == KIND_LIST);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind) inside
            KIND_LOAD, KIND_LIST: state_next = sts.full ? S_FULL : S_INS_CHK;
            KIND_REMOVE:          state_next = sts.empty ? S_EMPTY : S_REM_RD;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          state_next = list_after ? S_LST_RD : S_IDLE;
        end else begin
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.gt) begin
          state_next = S_INS_CHK;
        end else begin
          state_next = list_after ? S_LST_RD : S_IDLE;
        end
      end
      S_REM_RD:   state_next = S_REM_EMIT;
      S_REM_EMIT: if (sts.out_free) state_next = S_SHF_RD;
      S_SHF_RD: begin
        if (sts.idx_last) begin
          state_next = sts.count_one ? S_IDLE : S_LST_RD;
        end else begin
          state_next = S_SHF_WR;
        end
      end
      S_SHF_WR:   state_next = S_SHF_RD;
      S_LST_RD:   state_next = S_LST_EMIT;
      S_LST_EMIT: begin
        if (sts.out_free) begin
          state_next = sts.idx_last ? S_IDLE : S_LST_RD;
        end
      end
      S_FULL, S_EMPTY: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.idx_op      = IDX_HOLD;
    cmd.rd_addr     = RA_IDX;
    cmd.cnt_op      = CNT_HOLD;
    cmd.out_status  = ST_ENTRY;
    unique case (state)
      S_IDLE: begin
        cmd.load_val = accept;
        if (accept) begin
          cmd.idx_op = (kind == KIND_REMOVE) ? IDX_ZERO : IDX_COUNT;
        end
      end
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          // place the new value at the bottom
          cmd.wr_en       = 1'b1;
          cmd.wr_from_val = 1'b1;
          cmd.cnt_op      = CNT_INC;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_PREV;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.gt) begin
          // move the larger entry up one slot
          cmd.idx_op = IDX_DEC;
        end else begin
          cmd.wr_from_val = 1'b1;
          cmd.cnt_op      = CNT_INC;
          cmd.idx_op      = IDX_ZERO;
        end
      end
      S_REM_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_REM_EMIT: begin
        cmd.out_load   = sts.out_free;
        cmd.out_status = ST_REMOVED;
        cmd.out_last   = sts.count_one;
      end
      S_SHF_RD: begin
        if (sts.idx_last) begin
          cmd.cnt_op = CNT_DEC;
          cmd.idx_op = IDX_ZERO;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_NEXT;
        end
      end
      S_SHF_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_INC;
      end
      S_LST_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_LST_EMIT: begin
        cmd.out_load   = sts.out_free;
        cmd.out_status = ST_ENTRY;
        cmd.out_last   = sts.idx_last;
        if (sts.out_free && !sts.idx_last) begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_FULL: begin
        cmd.out_load   = sts.out_free;
        cmd.out_status = ST_FULL;
        cmd.out_zero   = 1'b1;
        cmd.out_last   = 1'b1;
      end
      S_EMPTY: begin
        cmd.out_load   = sts.out_free;
        cmd.out_status = ST_EMPTY;
        cmd.out_zero   = 1'b1;
        cmd.out_last   = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_controller and spq_datapath.
//
// Min-priority queue of up to CAPACITY signed 32-bit values, held in ascending
// order in a single-port-write, registered-read memory; equal values keep
// their arrival order. A kind 0 beat loads a value quietly, a kind 1 beat
// loads it and then lists every entry in order, a kind 2 beat returns the
// smallest value (status 1) and then lists what remains (status 0). Loading
// into a full queue drops the value and returns one full beat; removing from
// an empty queue returns one empty beat; kind 3 is ignored. The final result
// beat of each input carries last. One input beat is handled at a time:
// in_ready is high only while the controller is idle. The insert walk, the
// listing and the remove shift each read one entry at a time through the
// memory's registered port. The last result beat waits in the output
// register while the next input beat is taken, and any listing stalls
// cleanly when out_ready is low. No clearing pass is needed after reset:
// only entries below the count are ever read.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] value_res,
  output logic                     last
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each item: insert walk, remove shift, listing, status beats
  spq_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, index and count, plus the output register that parts the two sides
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .value_res (value_res),
    .last      (last)
  );

endmodule
